/* rtl/spr_anim_pkg.sv */
// Shared types and codes for the sprite animation sequencer.
package spr_anim_pkg;

    localparam int OP_W     = 3;
    localparam int IDX_W    = 6;
    localparam int FRAME_W  = 12;
    localparam int DUR_W    = 24;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 7;
    localparam int SPEED_W  = 16;
    localparam int MODE_W   = 2;
    localparam int PROD_W   = TIME_W + SPEED_W;
    localparam int ENTRY_W  = FRAME_W + DUR_W;

    localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd1;
    localparam logic [OP_W-1:0] OP_SEEK_T  = 3'd2;
    localparam logic [OP_W-1:0] OP_SEEK_S  = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd4;
    localparam logic [OP_W-1:0] OP_RESTART = 3'd5;

    localparam logic [MODE_W-1:0] MODE_ONCE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PING = 2'd2;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_SPEED = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_TOTAL = 10'b0000000010,
        S_MUL   = 10'b0000000100,
        S_ADD   = 10'b0000001000,
        S_MOD   = 10'b0000010000,
        S_PREP  = 10'b0000100000,
        S_FIND  = 10'b0001000000,
        S_FRD   = 10'b0010000000,
        S_FWAIT = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

endpackage

/* rtl/spr_anim_ram.sv */
// Generic RAM: one write port, one read port with registered read data.
module spr_anim_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/sprite_animation_sequencer.sv */
// Sprite animation sequencer: step table, playback time and step lookup.
// Each input is taken only in idle and runs to its result beat; write, restart, unused ops
// and advance while stopped only read the frame; seek step sweeps the table once; seek time
// and stop sweep it twice; advance sweeps it twice with a bit-serial modulo in between (no
// modulo in once mode, one sweep on zero total). A new input is taken after the result beat.
// Reset (async, rst_n low): time, step, playing cleared; mode loop, speed 1.0, count 0.
module sprite_animation_sequencer #(
    parameter int MAX_STEPS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0], step_sel[8:3], frame_index[20:9], step_duration[44:21],
    // time_value[76:45], zero pad
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_out[11:0], step_out[17:12], playing_out[18], time_out[50:19], zero pad
    output logic [55:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import spr_anim_pkg::*;

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int NW = $clog2(MAX_STEPS + 1);
    localparam int TW = DUR_W + NW;
    localparam int XW = (TW + 2 > 41) ? TW + 2 : 41;
    localparam logic [XW-1:0] TMAX = XW'(64'hFFFF_FFFF);

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [TIME_W-1:0]    tv_reg, tv_next;
    logic [TIME_W-1:0]    play_reg, play_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic                 playing_reg, playing_next;
    logic [MODE_W-1:0]    mode_reg;
    logic [SPEED_W-1:0]   speed_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic [NW-1:0]        pos_reg, pos_next;
    logic [NW-1:0]        lim_reg, lim_next;
    logic                 dv_reg, dv_next;
    logic [TW-1:0]        acc_reg, acc_next;
    logic [TW-1:0]        total_reg, total_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [XW-1:0]        eff_reg, eff_next;
    logic [XW-1:0]        rem_reg, rem_next;
    logic [XW-1:0]        div_reg, div_next;
    logic [TIME_W-1:0]    dvd_reg, dvd_next;
    logic [4:0]           bit_reg, bit_next;
    logic [FRAME_W-1:0]   frame_o_reg, frame_o_next;

    logic [NW-1:0]        n_valid;
    logic                 accept;
    logic [OP_W-1:0]      in_op;
    logic [IDX_W-1:0]     in_idx;
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [DUR_W-1:0]     rd_dur;
    logic [FRAME_W-1:0]   rd_frame;
    logic [TW-1:0]        acc_sum;
    logic [40:0]          add_sum;
    logic [TIME_W-1:0]    t_sat;
    logic [XW-1:0]        rem_shift;
    logic [XW-1:0]        tot2;
    logic [XW-1:0]        eff_c;
    logic [IDX_W-1:0]     sel_step;

    assign in_op  = s_tdata[2:0];
    assign in_idx = s_tdata[8:3];
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'd0, play_reg, playing_reg, cur_reg, frame_o_reg};

    assign n_valid = (32'(count_reg) > MAX_STEPS) ? NW'(MAX_STEPS) : NW'(count_reg);

    assign ram_we = accept && (in_op == OP_WRITE) && (32'(in_idx) < MAX_STEPS);
    assign rd_frame = ram_rdata[FRAME_W-1:0];
    assign rd_dur   = ram_rdata[ENTRY_W-1:FRAME_W];
    assign acc_sum  = acc_reg + TW'(rd_dur);

    assign sel_step = (NW'(cur_reg) < n_valid) ? cur_reg : IDX_W'(n_valid - NW'(1));
    assign ram_raddr = (state_reg == S_FRD) ? AW'(sel_step) : AW'(cnt_reg);

    spr_anim_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STEPS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_idx)),
        .wdata ({s_tdata[44:21], s_tdata[20:9]}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Advance sum, saturated to 32 bits
    assign add_sum = 41'(play_reg) + 41'(prod_reg[PROD_W-1:8]);
    assign t_sat   = (add_sum > 41'h0_FFFF_FFFF) ? '1 : add_sum[TIME_W-1:0];

    // One restoring-division step
    always_comb
    begin
        rem_shift = {rem_reg[XW-2:0], dvd_reg[TIME_W-1]};
        if (rem_shift >= div_reg)
        begin
            rem_shift = rem_shift - div_reg;
        end
    end

    // Effective time: ping-pong mirror, then cap at the total
    always_comb
    begin
        tot2  = XW'(total_reg) << 1;
        eff_c = XW'(play_reg);
        if (mode_reg == MODE_PING && eff_c > XW'(total_reg))
        begin
            eff_c = (eff_c > tot2) ? '0 : tot2 - eff_c;
        end
        if (eff_c > XW'(total_reg))
        begin
            eff_c = XW'(total_reg);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        tv_next      = tv_reg;
        play_next    = play_reg;
        cur_next     = cur_reg;
        playing_next = playing_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        lim_next     = lim_reg;
        dv_next      = dv_reg;
        acc_next     = acc_reg;
        total_next   = total_reg;
        prod_next    = prod_reg;
        eff_next     = eff_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        dvd_next     = dvd_reg;
        bit_next     = bit_reg;
        frame_o_next = frame_o_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = in_op;
                    tv_next  = s_tdata[76:45];
                    cnt_next = '0;
                    dv_next  = 1'b0;
                    acc_next = '0;
                    lim_next = n_valid;
                    state_next = S_FRD;
                    priority case (in_op)
                        OP_ADVANCE:
                        begin
                            if (playing_reg && n_valid != '0)
                            begin
                                state_next = S_TOTAL;
                            end
                        end
                        OP_SEEK_T:
                        begin
                            play_next  = s_tdata[76:45];
                            state_next = S_TOTAL;
                        end
                        OP_SEEK_S:
                        begin
                            if (n_valid == '0)
                            begin
                                cur_next  = '0;
                                play_next = '0;
                            end
                            else
                            begin
                                lim_next = (NW'(in_idx) >= n_valid || 32'(in_idx) >= MAX_STEPS)
                                         ? n_valid - NW'(1) : NW'(in_idx);
                                state_next = S_TOTAL;
                            end
                        end
                        OP_STOP:
                        begin
                            playing_next = 1'b0;
                            play_next    = '0;
                            state_next   = S_TOTAL;
                        end
                        OP_RESTART:
                        begin
                            play_next    = '0;
                            cur_next     = '0;
                            playing_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_TOTAL:
            begin
                // Address issued this cycle, data in the next
                dv_next = (cnt_reg < lim_reg);
                if (cnt_reg < lim_reg)
                begin
                    cnt_next = cnt_reg + NW'(1);
                end
                if (dv_reg)
                begin
                    acc_next = acc_sum;
                end
                if (cnt_reg >= lim_reg && !dv_reg)
                begin
                    total_next = acc_reg;
                    if (op_reg == OP_ADVANCE)
                    begin
                        if (acc_reg == '0)
                        begin
                            cur_next   = '0;
                            state_next = S_FRD;
                        end
                        else
                        begin
                            state_next = S_MUL;
                        end
                    end
                    else if (op_reg == OP_SEEK_S)
                    begin
                        play_next  = (XW'(acc_reg) > TMAX) ? '1 : TIME_W'(acc_reg);
                        cur_next   = IDX_W'(lim_reg);
                        state_next = S_FRD;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end

            S_MUL:
            begin
                prod_next  = PROD_W'(tv_reg) * PROD_W'(speed_reg);
                state_next = S_ADD;
            end

            S_ADD:
            begin
                dvd_next = t_sat;
                rem_next = '0;
                bit_next = 5'd31;
                if (mode_reg == MODE_LOOP)
                begin
                    div_next   = XW'(total_reg);
                    state_next = S_MOD;
                end
                else if (mode_reg == MODE_PING)
                begin
                    div_next   = XW'(total_reg) << 1;
                    state_next = S_MOD;
                end
                else
                begin
                    if (XW'(t_sat) >= XW'(total_reg))
                    begin
                        play_next    = TIME_W'(total_reg);
                        playing_next = 1'b0;
                    end
                    else
                    begin
                        play_next = t_sat;
                    end
                    state_next = S_PREP;
                end
            end

            S_MOD:
            begin
                rem_next = rem_shift;
                dvd_next = dvd_reg << 1;
                bit_next = bit_reg - 5'd1;
                if (bit_reg == 5'd0)
                begin
                    play_next  = rem_shift[TIME_W-1:0];
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                cnt_next = '0;
                dv_next  = 1'b0;
                acc_next = '0;
                eff_next = eff_c;
                if (total_reg == '0)
                begin
                    cur_next   = '0;
                    state_next = S_FRD;
                end
                else
                begin
                    state_next = S_FIND;
                end
            end

            S_FIND:
            begin
                dv_next = (cnt_reg < n_valid);
                if (cnt_reg < n_valid)
                begin
                    cnt_next = cnt_reg + NW'(1);
                    pos_next = cnt_reg;
                end
                if (dv_reg)
                begin
                    acc_next = acc_sum;
                    if (eff_reg < XW'(acc_sum))
                    begin
                        cur_next   = IDX_W'(pos_reg);
                        state_next = S_FRD;
                    end
                end
                if (cnt_reg >= n_valid && !dv_reg)
                begin
                    cur_next   = IDX_W'(n_valid - NW'(1));
                    state_next = S_FRD;
                end
            end

            S_FRD:
            begin
                state_next = S_FWAIT;
            end

            S_FWAIT:
            begin
                frame_o_next = (n_valid == '0) ? '0 : rd_frame;
                state_next   = S_OUT;
            end

            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            play_reg    <= '0;
            cur_reg     <= '0;
            playing_reg <= 1'b0;
            mode_reg    <= MODE_LOOP;
            speed_reg   <= 16'd256;
            count_reg   <= '0;
            cnt_reg     <= '0;
            dv_reg      <= 1'b0;
            bit_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            play_reg    <= play_next;
            cur_reg     <= cur_next;
            playing_reg <= playing_next;
            cnt_reg     <= cnt_next;
            dv_reg      <= dv_next;
            bit_reg     <= bit_next;
            if (cfg_we)
            begin
                priority case (cfg_index)
                    CFG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                    CFG_SPEED: speed_reg <= cfg_data;
                    CFG_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        tv_reg      <= tv_next;
        pos_reg     <= pos_next;
        lim_reg     <= lim_next;
        acc_reg     <= acc_next;
        total_reg   <= total_next;
        prod_reg    <= prod_next;
        eff_reg     <= eff_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        dvd_reg     <= dvd_next;
        frame_o_reg <= frame_o_next;
    end

endmodule

/* bench/testbench.sv */
// Self-checking bench for the sprite animation sequencer: table ops, playback and loop modes.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import spr_anim_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;   // acts as once
    localparam logic [OP_W-1:0]   OP_SPARE6  = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE7  = 3'd7;
    localparam int TBL_DEPTH   = 64;
    localparam int DRAIN_WAIT  = 200;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int STALL_LONG  = 400;

    typedef struct packed {
        logic [TIME_W-1:0]  tv;
        logic [DUR_W-1:0]   dur;
        logic [FRAME_W-1:0] frame;
        logic [IDX_W-1:0]   idx;
        logic [OP_W-1:0]    op;
    } anim_cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0]  time_v;
        logic               playing;
        logic [IDX_W-1:0]   step;
        logic [FRAME_W-1:0] frame;
    } anim_state_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    sprite_animation_sequencer DUT (.*);

    // predictor state
    logic [FRAME_W-1:0] tbl_frame [TBL_DEPTH];
    logic [DUR_W-1:0]   tbl_dur [TBL_DEPTH];
    logic [TIME_W-1:0]  play_pos;
    logic [IDX_W-1:0]   cur_step;
    logic               playing;
    logic [MODE_W-1:0]  mode_r;
    logic [SPEED_W-1:0] speed_r;
    logic [CNT_W-1:0]   count_r;

    anim_cmd_t   cmd_queue [$];
    anim_state_t state_queue [$];
    anim_cmd_t   cur_cmd;
    bit          written [TBL_DEPTH];
    bit          idling_on = 1;
    int          errors = 0;
    int          gap_tx, gap_rx, rx_seen, cycles;

    function automatic int n_valid();
        return (count_r > TBL_DEPTH) ? TBL_DEPTH : int'(count_r);
    endfunction

    function automatic logic [63:0] sum_durs(int upto);
        logic [63:0] t;
        t = 0;
        for (int i = 0; i < upto; i++)
            t += tbl_dur[i];
        return t;
    endfunction

    function automatic logic [TIME_W-1:0] sat_time(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [IDX_W-1:0] locate_step();
        int n;
        logic [63:0] total, eff, acc;
        n = n_valid();
        total = sum_durs(n);
        eff = play_pos;
        acc = 0;
        if (n == 0 || total == 0)
            return '0;
        if (mode_r == MODE_PING && eff > total)
            eff = (eff > 2 * total) ? 64'd0 : 2 * total - eff;
        if (eff > total)
            eff = total;
        for (int i = 0; i < n; i++)
        begin
            acc += tbl_dur[i];
            if (eff < acc)
                return IDX_W'(i);
        end
        return IDX_W'(n - 1);
    endfunction

    function automatic void advance_play(logic [TIME_W-1:0] dt);
        logic [63:0] total, t;
        if (!playing || n_valid() == 0)
            return;
        total = sum_durs(n_valid());
        if (total == 0)
        begin
            cur_step = '0;
            return;
        end
        t = {32'd0, play_pos} + ((64'(dt) * speed_r) >> 8);
        if (t > 64'hFFFF_FFFF)
            t = 64'hFFFF_FFFF;
        if (mode_r == MODE_LOOP)
            t = t % total;
        else if (mode_r == MODE_PING)
            t = t % (2 * total);
        else if (t >= total)
        begin
            t = total;
            playing = 1'b0;
        end
        play_pos = sat_time(t);
        cur_step = locate_step();
    endfunction

    // apply one accepted command and queue the state it should report
    function automatic void play_command(anim_cmd_t c);
        anim_state_t r;
        int n, s, tgt;
        n = n_valid();
        case (c.op)
            OP_WRITE:
            begin
                tbl_frame[c.idx] = c.frame;
                tbl_dur[c.idx] = c.dur;
            end
            OP_ADVANCE: advance_play(c.tv);
            OP_SEEK_T:
            begin
                play_pos = c.tv;
                cur_step = locate_step();
            end
            OP_SEEK_S:
            begin
                if (n == 0)
                begin
                    cur_step = '0;
                    play_pos = '0;
                end
                else
                begin
                    tgt = (c.idx >= n) ? n - 1 : int'(c.idx);
                    play_pos = sat_time(sum_durs(tgt));
                    cur_step = IDX_W'(tgt);
                end
            end
            OP_STOP:
            begin
                playing = 1'b0;
                play_pos = '0;
                cur_step = locate_step();
            end
            OP_RESTART:
            begin
                play_pos = '0;
                cur_step = '0;
                playing = 1'b1;
            end
            default: ;
        endcase
        r.frame = '0;
        if (n != 0)
        begin
            s = (cur_step < n) ? int'(cur_step) : n - 1;
            r.frame = tbl_frame[s];
        end
        r.step = cur_step;
        r.playing = playing;
        r.time_v = play_pos;
        state_queue.insert(state_queue.size(), r);
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            gap_tx <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                play_command(cur_cmd);
            if (!s_tvalid || s_tready)
            begin
                if (gap_tx > 0)
                begin
                    gap_tx <= gap_tx - 1;
                    s_tvalid <= 1'b0;
                end
                else if (idling_on && $urandom_range(0, 7) == 0)
                begin
                    gap_tx <= $urandom_range(0, 6);
                    s_tvalid <= 1'b0;
                end
                else if (cmd_queue.size() != 0)
                begin
                    cur_cmd = cmd_queue.pop_front();
                    s_tdata <= {3'b000, cur_cmd};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        anim_state_t got, want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            gap_rx <= 0;
            rx_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[50:0];
                rx_seen <= rx_seen + 1;
                if (state_queue.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", got);
                    errors++;
                end
                else
                begin
                    want = state_queue.pop_front();
                    if (got.frame !== want.frame)
                    begin
                        $error("frame_out exp %0d got %0d", want.frame, got.frame);
                        errors++;
                    end
                    if (got.step !== want.step)
                    begin
                        $error("step_out exp %0d got %0d", want.step, got.step);
                        errors++;
                    end
                    if (got.playing !== want.playing)
                    begin
                        $error("playing_out exp %0d got %0d", want.playing, got.playing);
                        errors++;
                    end
                    if (got.time_v !== want.time_v)
                    begin
                        $error("time_out exp %h got %h", want.time_v, got.time_v);
                        errors++;
                    end
                end
            end
            // one long hold-off so the block backs up onto its input
            if (m_tvalid && m_tready && rx_seen == 120)
            begin
                gap_rx <= STALL_LONG;
                m_tready <= 1'b0;
            end
            else if (gap_rx > 0)
            begin
                gap_rx <= gap_rx - 1;
                m_tready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                gap_rx <= $urandom_range(0, 6);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:  mode_r = val[MODE_W-1:0];
            CFG_SPEED: speed_r = val;
            default:   count_r = val[CNT_W-1:0];
        endcase
    endtask

    task automatic send(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                        logic [FRAME_W-1:0] fr, logic [DUR_W-1:0] dur,
                        logic [TIME_W-1:0] tv);
        anim_cmd_t c;
        c.op = op;
        c.idx = idx;
        c.frame = fr;
        c.dur = dur;
        c.tv = tv;
        if (op == OP_WRITE)
            written[idx] = 1;
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    // sampled mid-cycle so the sender's updates at the edge have settled
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || s_tvalid || state_queue.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic int written_prefix();
        for (int i = 0; i < TBL_DEPTH; i++)
            if (!written[i])
                return i;
        return TBL_DEPTH;
    endfunction

    function automatic logic [DUR_W-1:0] pick_dur();
        case ($urandom_range(0, 19))
            0, 1, 2:  return '0;
            3, 4:     return '1;
            5, 6, 7:  return DUR_W'($urandom);
            default:  return DUR_W'($urandom_range(1, 2048));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return '1;
            1, 2:    return $urandom;
            default: return $urandom_range(0, 4096);
        endcase
    endfunction

    initial
    begin
        int prefix, cnt, k;
        logic [15:0] spd;
        cycles = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        play_pos = '0;
        cur_step = '0;
        playing = 0;
        mode_r = MODE_LOOP;
        speed_r = 16'd256;
        count_r = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // empty table
        send(OP_RESTART, 0, 0, 0, 0);
        send(OP_ADVANCE, 0, 0, 0, '1);
        send(OP_SEEK_T, 0, 0, 0, '1);
        send(OP_SEEK_S, 63, 0, 0, 0);
        send(OP_STOP, 0, 0, 0, 0);
        send(OP_SPARE6, '1, '1, '1, '1);
        send(OP_SPARE7, 0, 0, 0, 0);
        send(OP_WRITE, 0, '1, 0, 0);
        send(OP_WRITE, 63, 0, '1, 0);
        wait_quiet();
        // zero total duration
        write_reg(CFG_COUNT, 1);
        send(OP_RESTART, 0, 0, 0, 0);
        send(OP_ADVANCE, 0, 0, 0, 100);
        send(OP_SEEK_S, 5, 0, 0, 0);
        for (int i = 1; i < 8; i++)
            send(OP_WRITE, IDX_W'(i), FRAME_W'($urandom),
                 (i == 7) ? '1 : DUR_W'($urandom_range(1, 500)), 0);
        send(OP_WRITE, 0, 12, 300, 0);
        wait_quiet();
        write_reg(CFG_COUNT, 8);
        write_reg(CFG_MODE, MODE_ONCE);
        write_reg(CFG_SPEED, 16'hFFFF);
        send(OP_RESTART, 0, 0, 0, 0);
        send(OP_ADVANCE, 0, 0, 0, 200);
        send(OP_ADVANCE, 0, 0, 0, '1);
        send(OP_SEEK_S, 63, 0, 0, 0);
        wait_quiet();
        // stale step: count shrinks under the current step
        write_reg(CFG_COUNT, 3);
        write_reg(CFG_MODE, MODE_SPARE);
        send(OP_SPARE6, 0, 0, 0, 0);
        wait_quiet();

        for (int ph = 0; ph < 26; ph++)
        begin
            if (ph >= 22)
                idling_on = 0;
            prefix = written_prefix();
            if (prefix == TBL_DEPTH && $urandom_range(0, 3) == 0)
                cnt = $urandom_range(TBL_DEPTH, 127);
            else
                cnt = $urandom_range(0, prefix);
            case ($urandom_range(0, 4))
                0:       spd = 16'd0;
                1:       spd = 16'hFFFF;
                2:       spd = 16'd256;
                default: spd = 16'($urandom);
            endcase
            write_reg(CFG_MODE, (ph < 4) ? MODE_W'(ph) : MODE_W'($urandom_range(0, 3)));
            write_reg(CFG_SPEED, spd);
            write_reg(CFG_COUNT, cnt[15:0]);
            send(OP_RESTART, 0, 0, 0, 0);
            for (int i = 0; i < 27; i++)
            begin
                k = $urandom_range(0, 99);
                if (k < 38)
                    send(OP_ADVANCE, IDX_W'($urandom), FRAME_W'($urandom),
                         DUR_W'($urandom), pick_time());
                else if (k < 56)
                    send(OP_WRITE, ($urandom_range(0, 1) != 0)
                         ? IDX_W'(written_prefix() % TBL_DEPTH) : IDX_W'($urandom),
                         FRAME_W'($urandom), pick_dur(), $urandom);
                else if (k < 68)
                    send(OP_SEEK_T, IDX_W'($urandom), FRAME_W'($urandom),
                         DUR_W'($urandom), pick_time());
                else if (k < 80)
                    send(OP_SEEK_S, IDX_W'($urandom), FRAME_W'($urandom),
                         DUR_W'($urandom), $urandom);
                else if (k < 85)
                    send(OP_STOP, IDX_W'($urandom), FRAME_W'($urandom),
                         DUR_W'($urandom), $urandom);
                else if (k < 96)
                    send(OP_RESTART, IDX_W'($urandom), FRAME_W'($urandom),
                         DUR_W'($urandom), $urandom);
                else
                    send((k < 98) ? OP_SPARE6 : OP_SPARE7, IDX_W'($urandom),
                         FRAME_W'($urandom), DUR_W'($urandom), $urandom);
            end
            wait_quiet();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/spr_anim_pkg.sv
rtl/spr_anim_ram.sv
rtl/sprite_animation_sequencer.sv
bench/testbench.sv
